// ----- rtl/fwrl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fwrl_pkg
// Shared types and constants of the fixed-window rate limiter: entry layout,
// outcome codes, register indexes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package fwrl_pkg;

	localparam int DEF_ENTRIES = 64;

	localparam int KEY_W   = 64;
	localparam int TIME_W  = 32;
	localparam int REG_W   = 16;
	localparam int COUNT_W = 17;
	localparam int OC_W    = 3;
	localparam int INDEX_W = 6;

	localparam logic [REG_W-1:0] LIMIT_RESET  = 16'd100;
	localparam logic [REG_W-1:0] WINDOW_RESET = 16'd60;

	// configuration register indexes
	localparam logic REG_LIMIT  = 1'b0;
	localparam logic REG_WINDOW = 1'b1;

	// outcome codes
	localparam logic [OC_W-1:0] OC_COUNTED  = 3'd0;
	localparam logic [OC_W-1:0] OC_NEW      = 3'd1;
	localparam logic [OC_W-1:0] OC_RESTART  = 3'd2;
	localparam logic [OC_W-1:0] OC_FULL     = 3'd3;
	localparam logic [OC_W-1:0] OC_EXCEEDED = 3'd4;

	// one row of the entry table
	typedef struct packed {
		logic [KEY_W-1:0]   key_high;
		logic [KEY_W-1:0]   key_low;
		logic [TIME_W-1:0]  span_start;
		logic [COUNT_W-1:0] count;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture request, rewind scan
		logic rd_en;   // read the entry at the scan address
		logic update;  // matched entry: count or restart, emit result
		logic miss;    // no match: claim free entry or flag full, emit result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;   // no entry in use
		logic more;    // entries left to read
		logic hit;     // entry in the compare register matches
		logic last;    // compare register holds the last entry in use
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/fwrl_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fwrl_ctrl
// Controller: accepts a request, walks the entry table until a match or the
// end of the entries in use, then orders the update or the new-entry step.
// ----------------------------------------------------------------------------
module fwrl_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire fwrl_pkg::sts_t  sts,
	output logic                 busy,
	output fwrl_pkg::cmd_t       cmd
);
	import fwrl_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;
	localparam logic [1:0] ST_MISS   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = sts.empty ? ST_MISS : ST_SCAN;
				end
			end
			ST_SCAN: begin
				// hold the compare register once it matches
				cmd.rd_en = sts.more && !sts.hit;
				if (sts.hit) begin
					state_d = ST_UPDATE;
				end else if (sts.last) begin
					state_d = ST_MISS;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_MISS: begin
				cmd.miss = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ----- rtl/fwrl_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fwrl_dp
// Datapath: configuration registers, entry memory with registered read,
// fill count, key compare, window and count arithmetic, result registers.
// ----------------------------------------------------------------------------
module fwrl_dp #(
	parameter int ENTRIES = fwrl_pkg::DEF_ENTRIES
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire fwrl_pkg::cmd_t               cmd,
	output fwrl_pkg::sts_t                    sts,
	input  wire logic                         cfg_write,
	input  wire logic                         cfg_index,
	input  wire logic [fwrl_pkg::REG_W-1:0]   cfg_data,
	input  wire logic [fwrl_pkg::KEY_W-1:0]   key_high,
	input  wire logic [fwrl_pkg::KEY_W-1:0]   key_low,
	input  wire logic [fwrl_pkg::TIME_W-1:0]  now_seconds,
	output logic                              result_valid,
	output logic                              allowed,
	output logic [fwrl_pkg::OC_W-1:0]         outcome,
	output logic [fwrl_pkg::INDEX_W-1:0]      entry_index,
	output logic [fwrl_pkg::COUNT_W-1:0]      count_after
);
	import fwrl_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

	// configuration
	logic [REG_W-1:0] limit_q;
	logic [REG_W-1:0] window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_LIMIT:  limit_q  <= cfg_data;
				REG_WINDOW: window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request registers
	logic [KEY_W-1:0]  req_high_q;
	logic [KEY_W-1:0]  req_low_q;
	logic [TIME_W-1:0] req_now_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_high_q <= key_high;
			req_low_q  <= key_low;
			req_now_q  <= now_seconds;
		end
	end

	// entries in use always form a prefix: they are never released
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] scan_q;
	logic             cmp_vld_q;
	logic [IDX_W-1:0] rd_idx_q;
	entry_t           rd_data_q;
	logic             full;

	assign full = (fill_q == FULL_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			scan_q    <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			cmp_vld_q <= cmd.rd_en;
			if (cmd.load) begin
				scan_q <= '0;
			end else if (cmd.rd_en) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (cmd.miss && !full) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	// entry memory
	entry_t           entry_mem_q [ENTRIES];
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_row;
	entry_t           hit_row;
	entry_t           new_row;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= entry_mem_q[scan_q[IDX_W-1:0]];
			rd_idx_q  <= scan_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_addr] <= wr_row;
		end
	end

	// status
	logic [CNT_W-1:0] next_idx;

	assign next_idx  = CNT_W'(rd_idx_q) + CNT_W'(1);
	assign sts.empty = (fill_q == '0);
	assign sts.more  = (scan_q < fill_q);
	assign sts.hit   = cmp_vld_q && (rd_data_q.key_high == req_high_q)
	                   && (rd_data_q.key_low == req_low_q);
	assign sts.last  = cmp_vld_q && (next_idx == fill_q);

	// window and count arithmetic on the matched entry
	logic [TIME_W-1:0]  age;
	logic               restart;
	logic [COUNT_W-1:0] cap;
	logic [COUNT_W-1:0] cnt_sat;
	logic               exceeded;

	assign age      = req_now_q - rd_data_q.span_start;
	assign restart  = (age >= TIME_W'(window_q));
	assign cap      = COUNT_W'(limit_q) + COUNT_W'(1);
	assign cnt_sat  = (rd_data_q.count >= cap) ? cap : rd_data_q.count + COUNT_W'(1);
	assign exceeded = (cnt_sat > COUNT_W'(limit_q));

	always_comb begin
		hit_row              = rd_data_q;
		hit_row.span_start   = restart ? req_now_q : rd_data_q.span_start;
		hit_row.count        = restart ? COUNT_W'(1) : cnt_sat;
		new_row.key_high     = req_high_q;
		new_row.key_low      = req_low_q;
		new_row.span_start   = req_now_q;
		new_row.count        = COUNT_W'(1);
	end

	assign wr_en   = cmd.update || (cmd.miss && !full);
	assign wr_addr = cmd.update ? rd_idx_q : fill_q[IDX_W-1:0];
	assign wr_row  = cmd.update ? hit_row : new_row;

	// entry number reported modulo 64
	logic [IDX_W+INDEX_W-1:0] hit_idx_ext;
	logic [IDX_W+INDEX_W-1:0] new_idx_ext;

	assign hit_idx_ext = (IDX_W + INDEX_W)'(rd_idx_q);
	assign new_idx_ext = (IDX_W + INDEX_W)'(fill_q[IDX_W-1:0]);

	// result registers
	logic               valid_q;
	logic               allowed_q;
	logic [OC_W-1:0]    outcome_q;
	logic [INDEX_W-1:0] index_q;
	logic [COUNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.update || cmd.miss;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			index_q <= hit_idx_ext[INDEX_W-1:0];
			if (restart) begin
				allowed_q <= 1'b1;
				outcome_q <= OC_RESTART;
				count_q   <= COUNT_W'(1);
			end else begin
				allowed_q <= !exceeded;
				outcome_q <= exceeded ? OC_EXCEEDED : OC_COUNTED;
				count_q   <= cnt_sat;
			end
		end else if (cmd.miss) begin
			allowed_q <= 1'b1;
			if (full) begin
				outcome_q <= OC_FULL;
				index_q   <= '0;
				count_q   <= '0;
			end else begin
				outcome_q <= OC_NEW;
				index_q   <= new_idx_ext[INDEX_W-1:0];
				count_q   <= COUNT_W'(1);
			end
		end
	end

	assign result_valid = valid_q;
	assign allowed      = allowed_q;
	assign outcome      = outcome_q;
	assign entry_index  = index_q;
	assign count_after  = count_q;

endmodule
`default_nettype wire

// ----- rtl/fixed_window_rate_limiter_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_window_rate_limiter_core
// Per-client request counter over fixed time windows, keyed by a 128-bit
// address, with a table of ENTRIES entries claimed in order.
//
//   channel   signals                                   handshake
//   request   key_high, key_low, now_seconds            start & !busy
//   result    allowed, outcome, entry_index,            result_valid, 1 cycle
//             count_after
//   config    cfg_index, cfg_data                       cfg_write
//
// A request walks the entries in use in order until a match or the last entry
// in use; on an empty table it goes straight to the new-entry step. The entry
// memory has one read port and is walked one entry per cycle. Reset clears the
// fill count and loads limit 100 and window 60; no clearing pass. The result is
// shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module fixed_window_rate_limiter_core #(
	parameter int ENTRIES = fwrl_pkg::DEF_ENTRIES
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic                         cfg_index,
	input  wire logic [fwrl_pkg::REG_W-1:0]   cfg_data,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [fwrl_pkg::KEY_W-1:0]   key_high,
	input  wire logic [fwrl_pkg::KEY_W-1:0]   key_low,
	input  wire logic [fwrl_pkg::TIME_W-1:0]  now_seconds,
	output logic                              result_valid,
	output logic                              allowed,
	output logic [fwrl_pkg::OC_W-1:0]         outcome,
	output logic [fwrl_pkg::INDEX_W-1:0]      entry_index,
	output logic [fwrl_pkg::COUNT_W-1:0]      count_after
);
	import fwrl_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic ctrl_busy;

	fwrl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (ctrl_busy),
		.cmd    (cmd)
	);

	fwrl_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.key_high     (key_high),
		.key_low      (key_low),
		.now_seconds  (now_seconds),
		.result_valid (result_valid),
		.allowed      (allowed),
		.outcome      (outcome),
		.entry_index  (entry_index),
		.count_after  (count_after)
	);

	assign busy = ctrl_busy;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for fixed_window_rate_limiter_core. A table of directed
// requests and register writes runs first, then random traffic in phases with
// different limits, windows and sender gaps. Untyped requests are predicted
// by a local model of the entry table; each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;

	import fwrl_pkg::*;

	localparam int TABLE_DEPTH = DEF_ENTRIES;
	localparam int POOL_SIZE   = 80;
	localparam int SETTLE      = 4;
	localparam int TAIL        = TABLE_DEPTH + 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DIR_ROWS    = 26;
	localparam int PHASES      = 5;

	localparam logic [KEY_W-1:0] KEY_ZERO = '0;
	localparam logic [KEY_W-1:0] KEY_ONES = '1;
	localparam logic [KEY_W-1:0] KEY_A_HI = 64'h0123_4567_89AB_CDEF;
	localparam logic [KEY_W-1:0] KEY_A_LO = 64'hFEDC_BA98_7654_3210;
	localparam logic [KEY_W-1:0] KEY_ONE  = 64'd1;
	localparam logic [KEY_W-1:0] KEY_MSB  = 64'h8000_0000_0000_0000;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic               allowed;
		logic [OC_W-1:0]    outcome;
		logic [INDEX_W-1:0] index;
		logic [COUNT_W-1:0] count;
	} verdict_t;

	typedef struct packed {
		row_kind_t          kind;
		logic               reg_sel;
		logic [REG_W-1:0]   reg_value;
		logic [KEY_W-1:0]   kh;
		logic [KEY_W-1:0]   kl;
		logic [TIME_W-1:0]  now;
		logic               typed;
		logic               ok;
		logic [OC_W-1:0]    oc;
		logic [INDEX_W-1:0] idx;
		logic [COUNT_W-1:0] cnt;
	} dir_row_t;

	typedef struct packed {
		logic [REG_W-1:0]  limit;
		logic [REG_W-1:0]  window;
		logic [7:0]        idle_pct;
		logic [7:0]        pool_first;
		logic [7:0]        pool_last;
		logic [15:0]       items;
		logic [TIME_W-1:0] time_base;
	} phase_t;

	// rows marked typed carry an expectation read straight off the spec
	dir_row_t directed_rows [0:DIR_ROWS-1] = '{
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ZERO, KEY_ZERO, 32'd0, 1'b1, 1'b1, OC_NEW, 6'd0, 17'd1},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ZERO, KEY_ZERO, 32'd59, 1'b1, 1'b1, OC_COUNTED, 6'd0, 17'd2},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ZERO, KEY_ZERO, 32'd60, 1'b1, 1'b1, OC_RESTART, 6'd0, 17'd1},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ONES, KEY_ONES, '1, 1'b1, 1'b1, OC_NEW, 6'd1, 17'd1},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ONES, KEY_ONES, 32'h3A, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ONES, KEY_ONES, 32'h3B, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_CFG, REG_LIMIT, 16'd0, KEY_ZERO, KEY_ZERO, 32'd0, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ZERO, KEY_ZERO, 32'd100, 1'b1, 1'b0, OC_EXCEEDED, 6'd0, 17'd1},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_A_HI, KEY_A_LO, 32'd100, 1'b1, 1'b1, OC_NEW, 6'd2, 17'd1},
		'{ROW_CFG, REG_WINDOW, 16'd0, KEY_ZERO, KEY_ZERO, 32'd0, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ZERO, KEY_ZERO, 32'd100, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_CFG, REG_LIMIT, 16'hFFFF, KEY_ZERO, KEY_ZERO, 32'd0, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_CFG, REG_WINDOW, 16'hFFFF, KEY_ZERO, KEY_ZERO, 32'd0, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_A_HI, KEY_A_LO, 32'd65634, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_A_HI, KEY_A_LO, 32'd65635, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_CFG, REG_LIMIT, 16'd3, KEY_ZERO, KEY_ZERO, 32'd0, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_CFG, REG_WINDOW, 16'd1000, KEY_ZERO, KEY_ZERO, 32'd0, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ZERO, KEY_ONE, 32'd2000, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ZERO, KEY_ONE, 32'd2000, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ZERO, KEY_ONE, 32'd2001, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ZERO, KEY_ONE, 32'd2002, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ZERO, KEY_ONE, 32'd2003, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_CFG, REG_LIMIT, 16'd1, KEY_ZERO, KEY_ZERO, 32'd0, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ZERO, KEY_ONE, 32'd2004, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_MSB, KEY_ZERO, 32'd2004, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0},
		'{ROW_REQ, REG_LIMIT, 16'd0, KEY_ZERO, KEY_MSB, '1, 1'b0, 1'b0, OC_COUNTED, 6'd0, 17'd0}
	};

	phase_t phases [0:PHASES-1] = '{
		'{16'd4, 16'd20, 8'd0, 8'd0, 8'd7, 16'd100, 32'd5000},
		'{16'd1, 16'd1, 8'd53, 8'd8, 8'd11, 16'd100, 32'd90000},
		'{16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 8'd39, 16'd100, 32'hFFFF_FF00},
		'{16'd0, 16'd0, 8'd14, 8'd0, 8'd15, 16'd90, 32'd123},
		'{16'd6, 16'd30, 8'd53, 8'd0, 8'd79, 16'd130, 32'h8000_0000}
	};

	logic                clk;
	logic                arst_n;
	logic                cfg_write;
	logic                cfg_index;
	logic [REG_W-1:0]    cfg_data;
	logic                start;
	logic                busy;
	logic [KEY_W-1:0]    key_high;
	logic [KEY_W-1:0]    key_low;
	logic [TIME_W-1:0]   now_seconds;
	logic                result_valid;
	logic                allowed;
	logic [OC_W-1:0]     outcome;
	logic [INDEX_W-1:0]  entry_index;
	logic [COUNT_W-1:0]  count_after;

	// local copy of the entry table and registers
	logic                model_valid [TABLE_DEPTH];
	logic [KEY_W-1:0]    model_key_hi [TABLE_DEPTH];
	logic [KEY_W-1:0]    model_key_lo [TABLE_DEPTH];
	logic [TIME_W-1:0]   model_start [TABLE_DEPTH];
	logic [COUNT_W-1:0]  model_count [TABLE_DEPTH];
	logic [REG_W-1:0]    model_limit;
	logic [REG_W-1:0]    model_window;

	logic [KEY_W-1:0]    pool_hi [POOL_SIZE];
	logic [KEY_W-1:0]    pool_lo [POOL_SIZE];

	verdict_t            pending_verdicts [$];
	int                  mismatch_count;
	int                  cycle_count;

	fixed_window_rate_limiter_core #(
		.ENTRIES(TABLE_DEPTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.key_high    (key_high),
		.key_low     (key_low),
		.now_seconds (now_seconds),
		.result_valid(result_valid),
		.allowed     (allowed),
		.outcome     (outcome),
		.entry_index (entry_index),
		.count_after (count_after)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** fixed_window_rate_limiter_core: FAILED **");
			$finish;
		end
	end

	// work out the verdict for one request and update the table copy
	function automatic verdict_t rate_check(input logic [KEY_W-1:0] kh,
			input logic [KEY_W-1:0] kl, input logic [TIME_W-1:0] now);
		int                 hit;
		int                 vacant;
		logic [TIME_W-1:0]  age;
		logic [COUNT_W-1:0] cap;
		logic [COUNT_W-1:0] cnt;
		verdict_t           v;
		hit = -1;
		vacant = -1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (model_valid[i]) begin
				if (hit < 0 && model_key_hi[i] == kh && model_key_lo[i] == kl)
					hit = i;
			end else if (vacant < 0) begin
				vacant = i;
			end
		end
		if (hit < 0) begin
			if (vacant < 0) begin
				v = '{1'b1, OC_FULL, '0, '0};
			end else begin
				model_valid[vacant] = 1'b1;
				model_key_hi[vacant] = kh;
				model_key_lo[vacant] = kl;
				model_start[vacant] = now;
				model_count[vacant] = 17'd1;
				v = '{1'b1, OC_NEW, INDEX_W'(vacant), 17'd1};
			end
			return v;
		end
		age = now - model_start[hit];
		if (age >= TIME_W'(model_window)) begin
			model_start[hit] = now;
			model_count[hit] = 17'd1;
			return '{1'b1, OC_RESTART, INDEX_W'(hit), 17'd1};
		end
		cap = COUNT_W'(model_limit) + 17'd1;
		cnt = (model_count[hit] >= cap) ? cap : model_count[hit] + 17'd1;
		model_count[hit] = cnt;
		if (cnt > COUNT_W'(model_limit))
			v = '{1'b0, OC_EXCEEDED, INDEX_W'(hit), cnt};
		else
			v = '{1'b1, OC_COUNTED, INDEX_W'(hit), cnt};
		return v;
	endfunction

	// hold start low until every pending verdict has come back
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [REG_W-1:0] value);
		wait_drained();
		cfg_write <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (sel == REG_LIMIT)
			model_limit = value;
		else
			model_window = value;
	endtask

	task automatic send_request(input logic [KEY_W-1:0] kh, input logic [KEY_W-1:0] kl,
			input logic [TIME_W-1:0] now, input int idle_pct,
			input logic typed, input verdict_t typed_verdict);
		verdict_t v;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(10, 70)) @(posedge clk);
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		key_high <= kh;
		key_low <= kl;
		now_seconds <= now;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		v = rate_check(kh, kl, now);
		if (typed)
			v = typed_verdict;
		pending_verdicts.push_back(v);
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && result_valid) begin
			if (pending_verdicts.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result allowed=%0b outcome=%0d index=%0d count=%0d",
						$realtime, allowed, outcome, entry_index, count_after);
			end else begin
				want = pending_verdicts.pop_front();
				if (allowed !== want.allowed || outcome !== want.outcome ||
						entry_index !== want.index || count_after !== want.count) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= 10)
						$display("%0t: mismatch exp %0b/%0d/%0d/%0d got %0b/%0d/%0d/%0d",
							$realtime, want.allowed, want.outcome, want.index, want.count,
							allowed, outcome, entry_index, count_after);
				end
			end
		end
	end

	initial begin
		logic [TIME_W-1:0] clock_now;
		logic [KEY_W-1:0]  kh;
		logic [KEY_W-1:0]  kl;
		int                pick;
		int                roll;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_LIMIT;
		cfg_data = '0;
		start = 1'b0;
		key_high = '0;
		key_low = '0;
		now_seconds = '0;
		mismatch_count = 0;
		cycle_count = 0;
		model_limit = LIMIT_RESET;
		model_window = WINDOW_RESET;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			model_valid[i] = 1'b0;
			model_key_hi[i] = '0;
			model_key_lo[i] = '0;
			model_start[i] = '0;
			model_count[i] = '0;
		end
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_hi[i] = {$urandom, $urandom};
			pool_lo[i] = {$urandom, $urandom};
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (directed_rows[r].kind == ROW_CFG)
				write_reg(directed_rows[r].reg_sel, directed_rows[r].reg_value);
			else
				send_request(directed_rows[r].kh, directed_rows[r].kl, directed_rows[r].now,
					0, directed_rows[r].typed, '{directed_rows[r].ok, directed_rows[r].oc,
					directed_rows[r].idx, directed_rows[r].cnt});
		end

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_LIMIT, phases[p].limit);
			write_reg(REG_WINDOW, phases[p].window);
			clock_now = phases[p].time_base;
			for (int n = 0; n < int'(phases[p].items); n++) begin
				if (p == 1 && n == int'(phases[p].items) / 2)
					wait_drained();
				// advance time: mostly still, sometimes past the window, rarely anywhere
				roll = $urandom_range(0, 99);
				if (roll >= 99)
					clock_now = $urandom;
				else if (roll >= 97)
					clock_now = clock_now + $urandom_range(0, int'(phases[p].window) + 2);
				else if (roll >= 70)
					clock_now = clock_now + $urandom_range(0, 3);
				// mostly keys from this phase's pool, some fresh random keys
				if ($urandom_range(0, 99) < 8) begin
					kh = {$urandom, $urandom};
					kl = {$urandom, $urandom};
				end else begin
					pick = $urandom_range(int'(phases[p].pool_first), int'(phases[p].pool_last));
					kh = pool_hi[pick];
					kl = pool_lo[pick];
				end
				send_request(kh, kl, clock_now, int'(phases[p].idle_pct), 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (mismatch_count == 0 && pending_verdicts.size() == 0)
			$display("** fixed_window_rate_limiter_core: PASSED **");
		else
			$display("** fixed_window_rate_limiter_core: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/fwrl_pkg.sv
rtl/fwrl_ctrl.sv
rtl/fwrl_dp.sv
rtl/fixed_window_rate_limiter_core.sv
tb/tb_top.sv
